>>> rtl/rphp_pkg.sv
// rphp_pkg: shared constants and widths for the redundant-audio payload header parser
// no dependencies; used by rtl/red_payload_header_parser.sv
`default_nettype none

package rphp_pkg;

    // default sizing of the top level
    localparam int unsigned MAX_BLOCKS_DEF = 4;
    localparam int unsigned MAX_BYTES_DEF  = 2048;

    // header layout
    localparam int unsigned PT_W       = 7;   // payload type
    localparam int unsigned TS_W       = 14;  // timestamp offset
    localparam int unsigned BLK_LEN_W  = 10;  // redundant block length
    localparam int unsigned HDR_MORE_BIT = 7; // set: another redundant header follows

    // header byte index: 0 is the type byte, 1..3 the offset/length bytes
    localparam logic [1:0] HDR_IDX_TYPE = 2'd0;
    localparam logic [1:0] HDR_IDX_LAST = 2'd3;

    // record field widths
    localparam int unsigned BIDX_W = 2;
    localparam int unsigned LEN_W  = 12;
    localparam int unsigned OFS_W  = 11;

    // word widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned M_USER_W = 2;

    // record kind codes
    localparam logic KIND_BLOCK   = 1'b0;
    localparam logic KIND_PRIMARY = 1'b1;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

endpackage

`default_nettype wire

>>> rtl/red_payload_header_parser.sv
// red_payload_header_parser: byte-wide parser of redundant-audio payload headers
// depends on rtl/rphp_pkg.sv (scoped names only)
`default_nettype none

// channel   dir  tdata                                    tuser             tlast
// s (in)    in   [7:0] data_byte                          -                 last_byte
// m (out)   out  [1:0] block_index, [15:2] ts_delta,      [0] status,       last
//                [27:16] length, [38:28] data_offset       [1] kind
// cfg       in   i_cfg_wr_data = expected_payload_type, written when i_cfg_wr_en
//
// one payload byte per cycle: an input register feeds the parse logic, which
// updates the packet state in a single pass, so bytes flow back to back
// at the last byte the finished packet is copied into a record buffer that drains
// one record per ready cycle (block records then primary, or one error record)
// the input stalls only when a last byte meets a buffer whose records are not
// all taken yet; a full record run is at most MAX_BLOCKS + 1 records
// synchronous active-low reset clears the packet state, buffer and register

module red_payload_header_parser #(
    parameter int unsigned MAX_BLOCKS = rphp_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned MAX_BYTES  = rphp_pkg::MAX_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [rphp_pkg::PT_W-1:0]      i_cfg_wr_data,
    // payload byte stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [rphp_pkg::S_DATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic                           i_s_tlast,   // last_byte
    // record stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [rphp_pkg::M_DATA_W-1:0]       o_m_tdata,   // block_index, ts_delta,
                                                             // length, data_offset, pad
    output logic [rphp_pkg::M_USER_W-1:0]       o_m_tuser,   // status, kind
    output logic                                o_m_tlast    // last
);

    // widths that follow from the sizing parameters
    localparam int unsigned CNT_W = $clog2(MAX_BYTES + 2);          // holds MAX_BYTES + 1
    localparam int unsigned BC_W  = $clog2(MAX_BLOCKS + 1);         // holds MAX_BLOCKS
    localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned DT_W  = $clog2(MAX_BLOCKS * ((1 << rphp_pkg::BLK_LEN_W) - 1) + 1);
    localparam int unsigned SUM_W = ((CNT_W > DT_W) ? CNT_W : DT_W) + 1;

    localparam logic [CNT_W-1:0] MAX_BYTES_C  = CNT_W'(MAX_BYTES);
    localparam logic [BC_W-1:0]  MAX_BLOCKS_C = BC_W'(MAX_BLOCKS);

    // configuration register
    logic [rphp_pkg::PT_W-1:0] r_ept;

    // input register
    logic                          r_in_v;
    logic [rphp_pkg::S_DATA_W-1:0] r_in_byte;
    logic                          r_in_last;

    // packet state
    logic              r_in_header;
    logic [1:0]        r_hbi;
    logic [15:0]       r_hb;        // first two offset/length bytes of a header
    logic [BC_W-1:0]   r_bc;
    logic [DT_W-1:0]   r_dt;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_hl;
    logic              r_mal;

    // block table, written once per redundant header, no reset
    logic [rphp_pkg::TS_W-1:0]      r_blk_ts  [MAX_BLOCKS];
    logic [rphp_pkg::BLK_LEN_W-1:0] r_blk_len [MAX_BLOCKS];

    // record buffer
    logic                           r_o_v;
    logic                           r_o_mal;
    logic [BC_W-1:0]                r_o_cnt;
    logic [BC_W-1:0]                r_o_idx;
    logic [rphp_pkg::OFS_W-1:0]     r_o_dpos;
    logic [rphp_pkg::LEN_W-1:0]     r_o_prim;
    logic [rphp_pkg::TS_W-1:0]      r_o_ts  [MAX_BLOCKS];
    logic [rphp_pkg::BLK_LEN_W-1:0] r_o_len [MAX_BLOCKS];

    // next-state of the parse pass
    logic              n_in_header;
    logic [1:0]        n_hbi;
    logic [15:0]       n_hb;
    logic [BC_W-1:0]   n_bc;
    logic [DT_W-1:0]   n_dt;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  n_hl;
    logic              n_mal;
    logic              blk_we;
    logic [23:0]       hdr_word;
    logic [rphp_pkg::TS_W-1:0]      hdr_ts;
    logic [rphp_pkg::BLK_LEN_W-1:0] hdr_len;
    logic              type_bad;
    logic [SUM_W-1:0]  used_sum;
    logic [SUM_W-1:0]  prim_full;
    logic              fin_mal;

    // handshake control
    logic              rec_last;
    logic              o_fire;
    logic              buf_free;
    logic              s1_go;

    // -------------------------------------------------------------------------
    // handshake
    // -------------------------------------------------------------------------
    assign rec_last   = r_o_mal || (r_o_idx == r_o_cnt);
    assign o_fire     = r_o_v && i_m_tready;
    assign buf_free   = !r_o_v || (i_m_tready && rec_last);
    assign s1_go      = r_in_v && (!r_in_last || buf_free);
    assign o_s_tready = !r_in_v || s1_go;

    // -------------------------------------------------------------------------
    // parse pass for the registered byte
    // -------------------------------------------------------------------------
    assign hdr_word = {r_hb, r_in_byte};
    assign hdr_ts   = hdr_word[23:10];
    assign hdr_len  = hdr_word[9:0];
    assign type_bad = (r_in_byte[rphp_pkg::PT_W-1:0] != r_ept);

    always_comb begin
        n_in_header = r_in_header;
        n_hbi       = r_hbi;
        n_hb        = r_hb;
        n_bc        = r_bc;
        n_dt        = r_dt;
        n_hl        = r_hl;
        blk_we      = 1'b0;

        // byte counter saturates one past the limit
        n_cnt = (r_cnt <= MAX_BYTES_C) ? r_cnt + 1'b1 : r_cnt;
        n_mal = r_mal || (n_cnt > MAX_BYTES_C);

        if (!n_mal && r_in_header) begin
            if (r_hbi == rphp_pkg::HDR_IDX_TYPE) begin
                if (r_in_byte[rphp_pkg::HDR_MORE_BIT]) begin
                    // redundant header type byte
                    if (r_bc >= MAX_BLOCKS_C || type_bad) begin
                        n_mal = 1'b1;
                    end else begin
                        n_hb  = '0;
                        n_hbi = 2'd1;
                    end
                end else begin
                    // one-byte final header of the primary
                    if (type_bad) begin
                        n_mal = 1'b1;
                    end else begin
                        n_in_header = 1'b0;
                        n_hl        = n_cnt;
                    end
                end
            end else begin
                n_hb = hdr_word[15:0];
                if (r_hbi != rphp_pkg::HDR_IDX_LAST) begin
                    n_hbi = r_hbi + 2'd1;
                end else begin
                    n_hbi = rphp_pkg::HDR_IDX_TYPE;
                    if (hdr_ts == '0 || r_bc >= MAX_BLOCKS_C) begin
                        n_mal = 1'b1;
                    end else begin
                        blk_we = 1'b1;
                        n_bc   = r_bc + 1'b1;
                        n_dt   = r_dt + DT_W'(hdr_len);
                    end
                end
            end
        end

        // end-of-packet checks: unfinished headers, overlong blocks, empty primary
        used_sum  = SUM_W'(n_hl) + SUM_W'(n_dt);
        prim_full = SUM_W'(n_cnt) - used_sum;
        fin_mal   = n_mal || n_in_header || (used_sum > SUM_W'(n_cnt)) || (prim_full == '0);
    end

    // -------------------------------------------------------------------------
    // control registers
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ept       <= '0;
            r_in_v      <= 1'b0;
            r_in_header <= 1'b1;
            r_hbi       <= rphp_pkg::HDR_IDX_TYPE;
            r_hb        <= '0;
            r_bc        <= '0;
            r_dt        <= '0;
            r_cnt       <= '0;
            r_hl        <= '0;
            r_mal       <= 1'b0;
            r_o_v       <= 1'b0;
            r_o_idx     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ept <= i_cfg_wr_data;
            end

            if (o_s_tready) begin
                r_in_v <= i_s_tvalid;
            end

            if (s1_go) begin
                if (r_in_last) begin
                    // packet done: clear for the next one
                    r_in_header <= 1'b1;
                    r_hbi       <= rphp_pkg::HDR_IDX_TYPE;
                    r_hb        <= '0;
                    r_bc        <= '0;
                    r_dt        <= '0;
                    r_cnt       <= '0;
                    r_hl        <= '0;
                    r_mal       <= 1'b0;
                end else begin
                    r_in_header <= n_in_header;
                    r_hbi       <= n_hbi;
                    r_hb        <= n_hb;
                    r_bc        <= n_bc;
                    r_dt        <= n_dt;
                    r_cnt       <= n_cnt;
                    r_hl        <= n_hl;
                    r_mal       <= n_mal;
                end
            end

            // record buffer: a new packet load wins over the final drain
            if (s1_go && r_in_last) begin
                r_o_v   <= 1'b1;
                r_o_idx <= '0;
            end else if (o_fire) begin
                if (rec_last) begin
                    r_o_v <= 1'b0;
                end else begin
                    r_o_idx <= r_o_idx + 1'b1;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // payload registers
    // -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end

        if (s1_go && blk_we) begin
            r_blk_ts[r_bc[IDX_W-1:0]]  <= hdr_ts;
            r_blk_len[r_bc[IDX_W-1:0]] <= hdr_len;
        end

        if (s1_go && r_in_last) begin
            r_o_mal  <= fin_mal;
            r_o_cnt  <= n_bc;
            r_o_dpos <= rphp_pkg::OFS_W'(n_hl);
            r_o_prim <= rphp_pkg::LEN_W'(prim_full);
            r_o_ts   <= r_blk_ts;
            r_o_len  <= r_blk_len;
        end else if (o_fire && !rec_last) begin
            // next block's data starts after this one
            r_o_dpos <= r_o_dpos
                        + rphp_pkg::OFS_W'(r_o_len[r_o_idx[IDX_W-1:0]]);
        end
    end

    // -------------------------------------------------------------------------
    // record formatting
    // -------------------------------------------------------------------------
    logic                       rec_status;
    logic                       rec_kind;
    logic [rphp_pkg::BIDX_W-1:0] rec_idx;
    logic [rphp_pkg::TS_W-1:0]  rec_ts;
    logic [rphp_pkg::LEN_W-1:0] rec_len;
    logic [rphp_pkg::OFS_W-1:0] rec_ofs;

    always_comb begin
        rec_status = rphp_pkg::STATUS_OK;
        rec_kind   = rphp_pkg::KIND_PRIMARY;
        rec_idx    = '0;
        rec_ts     = '0;
        rec_len    = r_o_prim;
        rec_ofs    = r_o_dpos;
        if (r_o_mal) begin
            // error record: everything but status and last is zero
            rec_status = rphp_pkg::STATUS_BAD;
            rec_kind   = rphp_pkg::KIND_BLOCK;
            rec_len    = '0;
            rec_ofs    = '0;
        end else if (!rec_last) begin
            rec_kind = rphp_pkg::KIND_BLOCK;
            rec_idx  = rphp_pkg::BIDX_W'(r_o_idx);
            rec_ts   = r_o_ts[r_o_idx[IDX_W-1:0]];
            rec_len  = rphp_pkg::LEN_W'(r_o_len[r_o_idx[IDX_W-1:0]]);
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = {1'b0, rec_ofs, rec_len, rec_ts, rec_idx};
    assign o_m_tuser  = {rec_kind, rec_status};
    assign o_m_tlast  = rec_last;

    // -------------------------------------------------------------------------
    // assertions
    // -------------------------------------------------------------------------
    a_reset_quiet : assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("record valid right after reset");

    a_error_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("error record not marked last");

    a_idx_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o_idx <= r_o_cnt))
        else $error("record index ran past block count");

    a_hdr_in_header : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hbi != rphp_pkg::HDR_IDX_TYPE) |-> r_in_header)
        else $error("header byte index set outside header section");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !s1_go) |=> (r_in_v && $stable(r_in_last)))
        else $error("held input word lost while stalled");

endmodule

`default_nettype wire
